>>> design/lvm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the look-at view matrix core.
// No dependencies.
package lvm_pkg;

    typedef struct packed {
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } t_in;

    typedef struct packed {
        logic [1:0]         row;
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic signed [31:0] offset;
        logic               degenerate;
        logic               last;
    } t_out;

    localparam logic [1:0] ROW_SIDE = 2'd0;
    localparam logic [1:0] ROW_UP   = 2'd1;
    localparam logic [1:0] ROW_FWD  = 2'd2;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

endpackage

>>> design/lookat_view_matrix_core.sv
`timescale 1ns / 1ps
// Left-handed look-at view matrix, world up (0,1,0), fully pipelined.
// Depends on lvm_pkg.
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+---------------------------
//  input   | i_in_valid | o_in_ready  | i_in_data  (lvm_pkg::t_in)
//  output  | o_out_valid| i_out_ready | o_out_data (lvm_pkg::t_out)
//
// Each item yields three rows from the output register. The row serialiser
// at the output loads the next item as the last row of the current one is
// taken, so it sets the sustained rate.
// The pipeline (31 square-root stages, 31 divider stages, multiply stages)
// advances as one; it stalls only while its last stage holds an item that
// the serialiser cannot take. Reset is synchronous and clears valid bits.
module lookat_view_matrix_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lvm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output lvm_pkg::t_out o_out_data
);

    localparam int NSQ    = 31;
    localparam int NDV    = 31;
    localparam int S_D    = 0;
    localparam int S_MAG  = 1;
    localparam int S_NRM  = 2;
    localparam int S_SQ   = 3;
    localparam int S_SUM  = 4;
    localparam int S_RT0  = 5;
    localparam int S_DV0  = S_RT0 + NSQ;
    localparam int S_SGN  = S_DV0 + NDV + 1;
    localparam int S_M1   = S_SGN + 1;
    localparam int S_M2   = S_SGN + 2;
    localparam int S_UP   = S_SGN + 3;
    localparam int S_O1   = S_SGN + 4;
    localparam int S_O2   = S_SGN + 5;
    localparam int S_OFF  = S_SGN + 6;
    localparam int NST    = S_OFF + 1;

    localparam logic [36:0] ONE_Q30_U = 37'h0_4000_0000;

    typedef struct packed {
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] ez;
        logic [2:0]         fneg;
        logic               sxneg;
        logic               szneg;
        logic               degen;
    } t_ctx;

    typedef struct packed {
        logic [61:0] v;
        logic [61:0] r;
    } t_rt;

    typedef struct packed {
        logic [30:0] rem;
        logic [30:0] nlo;
        logic [30:0] q;
    } t_dv;

    function automatic logic [5:0] msb33(input logic [32:0] x);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 33; i++) begin
            if (x[i]) p = 6'(i);
        end
        return p;
    endfunction

    function automatic logic [29:0] nrm(input logic [32:0] x, input logic [5:0] p);
        logic [32:0] t;
        if (p >= 6'd30) t = x >> (p - 6'd29);
        else            t = x << (6'd29 - p);
        return t[29:0];
    endfunction

    function automatic t_rt rt_step(input t_rt a, input logic [61:0] b);
        t_rt o;
        if (a.v >= a.r + b) begin
            o.v = a.v - (a.r + b);
            o.r = (a.r >> 1) + b;
        end else begin
            o.v = a.v;
            o.r = a.r >> 1;
        end
        return o;
    endfunction

    function automatic t_dv dv_step(input t_dv a, input logic [30:0] d);
        t_dv o;
        logic [31:0] t;
        logic qb;
        t  = {a.rem, a.nlo[30]};
        qb = (t >= {1'b0, d});
        o.rem = qb ? 31'(t - {1'b0, d}) : t[30:0];
        o.nlo = {a.nlo[29:0], 1'b0};
        o.q   = {a.q[29:0], qb};
        return o;
    endfunction

    // magnitude rounded right by 30, halves away from zero
    function automatic logic [36:0] rnd_mag(input logic signed [65:0] v);
        logic [65:0] m;
        m = v[65] ? 66'(-v) : 66'(v);
        return 37'((m + 66'(1 << 29)) >> 30);
    endfunction

    function automatic logic signed [31:0] dv_unit(input logic [30:0] q, input logic neg);
        return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    logic               en;
    logic               ser_load;
    logic               r_v   [NST];
    t_ctx               r_ctx [NST];

    logic signed [32:0] r_d   [3];
    logic [32:0]        r_fm  [3];
    logic [29:0]        r_fn  [S_NRM:S_DV0-1][3];
    logic [29:0]        r_sn  [S_NRM:S_DV0-1][2];
    logic [59:0]        r_fq  [3];
    logic [59:0]        r_sq  [2];
    logic [61:0]        r_fs;
    logic [61:0]        r_ss;
    t_rt                r_frt [NSQ];
    t_rt                r_srt [NSQ];
    logic [30:0]        r_flen [S_DV0:S_DV0+NDV-1];
    logic [30:0]        r_slen [S_DV0:S_DV0+NDV-1];
    t_dv                r_fdv [S_DV0:S_DV0+NDV][3];
    t_dv                r_sdv [S_DV0:S_DV0+NDV][2];
    logic signed [31:0] r_f   [S_SGN:S_OFF][3];
    logic signed [31:0] r_s   [S_SGN:S_OFF][3];
    logic signed [63:0] r_p   [4];
    logic [36:0]        r_um  [3];
    logic               r_un  [3];
    logic signed [31:0] r_u   [S_UP:S_OFF][3];
    logic signed [63:0] r_op  [3][3];
    logic [36:0]        r_om  [3];
    logic               r_on  [3];
    logic signed [31:0] r_off [3];

    logic               r_sval;
    logic [1:0]         r_row;
    logic signed [31:0] r_ax  [3][3];
    logic signed [31:0] r_of  [3];
    logic               r_dg;

    t_ctx               n_ctx;
    logic signed [32:0] n_d   [3];
    logic [29:0]        n_fn  [3];
    logic [29:0]        n_sn  [2];
    t_rt                n_frt [NSQ];
    t_rt                n_srt [NSQ];
    t_dv                n_fdv [S_DV0:S_DV0+NDV][3];
    t_dv                n_sdv [S_DV0:S_DV0+NDV][2];
    logic signed [31:0] n_f   [3];
    logic signed [31:0] n_s   [3];
    logic signed [31:0] n_u   [3];
    logic signed [31:0] n_off [3];
    logic signed [31:0] axes  [3][3];

    assign ser_load   = r_v[S_OFF] && (!r_sval || (i_out_ready && r_row == lvm_pkg::ROW_FWD));
    assign en         = !r_v[S_OFF] || ser_load;
    assign o_in_ready = en;

    always_comb begin
        logic [32:0] fmax, smax;
        logic [5:0]  fp, sp;
        logic [60:0] num;
        logic [61:0] bitv;

        n_ctx.ex    = i_in_data.eye_x;
        n_ctx.ey    = i_in_data.eye_y;
        n_ctx.ez    = i_in_data.eye_z;
        n_d[0] = 33'(i_in_data.target_x) - 33'(i_in_data.eye_x);
        n_d[1] = 33'(i_in_data.target_y) - 33'(i_in_data.eye_y);
        n_d[2] = 33'(i_in_data.target_z) - 33'(i_in_data.eye_z);
        n_ctx.fneg  = {n_d[2][32], n_d[1][32], n_d[0][32]};
        n_ctx.sxneg = n_d[2][32];
        n_ctx.szneg = !n_d[0][32] && (n_d[0] != '0);
        n_ctx.degen = (n_d[0] == '0) && (n_d[2] == '0);

        // block normalisation: largest magnitude lands in [2^29, 2^30)
        fmax = (r_fm[0] > r_fm[1]) ? r_fm[0] : r_fm[1];
        fmax = (r_fm[2] > fmax) ? r_fm[2] : fmax;
        smax = (r_fm[2] > r_fm[0]) ? r_fm[2] : r_fm[0];
        fp   = msb33(fmax);
        sp   = msb33(smax);
        for (int j = 0; j < 3; j++) n_fn[j] = nrm(r_fm[j], fp);
        n_sn[0] = nrm(r_fm[2], sp);
        n_sn[1] = nrm(r_fm[0], sp);

        for (int k = 0; k < NSQ; k++) begin
            bitv = 62'd1 << (60 - 2 * k);
            if (k == 0) begin
                n_frt[k] = rt_step('{v: r_fs, r: '0}, bitv);
                n_srt[k] = rt_step('{v: r_ss, r: '0}, bitv);
            end else begin
                n_frt[k] = rt_step(r_frt[k-1], bitv);
                n_srt[k] = rt_step(r_srt[k-1], bitv);
            end
        end

        for (int j = 0; j < 3; j++) begin
            num = {1'b0, r_fn[S_DV0-1][j], 30'd0} + 61'(r_frt[NSQ-1].r[30:1]);
            n_fdv[S_DV0][j] = '{rem: {1'b0, num[60:31]}, nlo: num[30:0], q: '0};
        end
        for (int j = 0; j < 2; j++) begin
            num = {1'b0, r_sn[S_DV0-1][j], 30'd0} + 61'(r_srt[NSQ-1].r[30:1]);
            n_sdv[S_DV0][j] = '{rem: {1'b0, num[60:31]}, nlo: num[30:0], q: '0};
        end
        for (int k = S_DV0 + 1; k <= S_DV0 + NDV; k++) begin
            for (int j = 0; j < 3; j++) n_fdv[k][j] = dv_step(r_fdv[k-1][j], r_flen[k-1]);
            for (int j = 0; j < 2; j++) n_sdv[k][j] = dv_step(r_sdv[k-1][j], r_slen[k-1]);
        end

        for (int j = 0; j < 3; j++) begin
            n_f[j] = dv_unit(r_fdv[S_DV0+NDV][j].q, r_ctx[S_SGN-1].fneg[j]);
        end
        n_s[0] = dv_unit(r_sdv[S_DV0+NDV][0].q, r_ctx[S_SGN-1].sxneg);
        n_s[1] = '0;
        n_s[2] = dv_unit(r_sdv[S_DV0+NDV][1].q, r_ctx[S_SGN-1].szneg);
        if (r_ctx[S_SGN-1].degen) begin
            for (int j = 0; j < 3; j++) begin
                n_f[j] = '0;
                n_s[j] = '0;
            end
        end

        for (int j = 0; j < 3; j++) begin
            if (r_um[j] > ONE_Q30_U) n_u[j] = r_un[j] ? -lvm_pkg::ONE_Q30
                                                      : lvm_pkg::ONE_Q30;
            else n_u[j] = r_un[j] ? -$signed(r_um[j][31:0]) : $signed(r_um[j][31:0]);
        end

        for (int k = 0; k < 3; k++) begin
            if (r_on[k]) begin
                n_off[k] = (r_om[k] > 37'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                       : $signed(r_om[k][31:0]);
            end else begin
                n_off[k] = (r_om[k] > 37'h0_8000_0000) ? 32'sh8000_0000
                                                       : -$signed(r_om[k][31:0]);
            end
        end

        for (int j = 0; j < 3; j++) begin
            axes[0][j] = r_s[S_O1-1][j];
            axes[1][j] = r_u[S_O1-1][j];
            axes[2][j] = r_f[S_O1-1][j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_v[k] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_in_valid;
            for (int k = 1; k < NST; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctx[0] <= n_ctx;
            for (int k = 1; k < NST; k++) r_ctx[k] <= r_ctx[k-1];

            r_d <= n_d;
            for (int j = 0; j < 3; j++) begin
                r_fm[j] <= r_d[j][32] ? 33'(-r_d[j]) : 33'(r_d[j]);
            end

            r_fn[S_NRM] <= n_fn;
            r_sn[S_NRM] <= n_sn;
            for (int k = S_NRM + 1; k < S_DV0; k++) begin
                r_fn[k] <= r_fn[k-1];
                r_sn[k] <= r_sn[k-1];
            end

            for (int j = 0; j < 3; j++) r_fq[j] <= r_fn[S_NRM][j] * r_fn[S_NRM][j];
            for (int j = 0; j < 2; j++) r_sq[j] <= r_sn[S_NRM][j] * r_sn[S_NRM][j];
            r_fs <= 62'(r_fq[0]) + 62'(r_fq[1]) + 62'(r_fq[2]);
            r_ss <= 62'(r_sq[0]) + 62'(r_sq[1]);

            r_frt <= n_frt;
            r_srt <= n_srt;

            r_flen[S_DV0] <= r_frt[NSQ-1].r[30:0];
            r_slen[S_DV0] <= r_srt[NSQ-1].r[30:0];
            for (int k = S_DV0 + 1; k < S_DV0 + NDV; k++) begin
                r_flen[k] <= r_flen[k-1];
                r_slen[k] <= r_slen[k-1];
            end
            r_fdv <= n_fdv;
            r_sdv <= n_sdv;

            r_f[S_SGN] <= n_f;
            r_s[S_SGN] <= n_s;
            for (int k = S_SGN + 1; k <= S_OFF; k++) begin
                r_f[k] <= r_f[k-1];
                r_s[k] <= r_s[k-1];
            end

            // up = forward x side, side_y being zero
            r_p[0] <= r_f[S_SGN][1] * r_s[S_SGN][2];
            r_p[1] <= r_f[S_SGN][2] * r_s[S_SGN][0];
            r_p[2] <= r_f[S_SGN][0] * r_s[S_SGN][2];
            r_p[3] <= r_f[S_SGN][1] * r_s[S_SGN][0];

            r_um[0] <= rnd_mag(66'(r_p[0]));
            r_un[0] <= r_p[0][63];
            r_um[1] <= rnd_mag(66'(r_p[1]) - 66'(r_p[2]));
            r_un[1] <= (66'(r_p[1]) - 66'(r_p[2])) < 0;
            r_um[2] <= rnd_mag(-66'(r_p[3]));
            r_un[2] <= (-66'(r_p[3])) < 0;

            r_u[S_UP] <= n_u;
            for (int k = S_UP + 1; k <= S_OFF; k++) r_u[k] <= r_u[k-1];

            for (int k = 0; k < 3; k++) begin
                r_op[k][0] <= axes[k][0] * r_ctx[S_O1-1].ex;
                r_op[k][1] <= axes[k][1] * r_ctx[S_O1-1].ey;
                r_op[k][2] <= axes[k][2] * r_ctx[S_O1-1].ez;
            end
            for (int k = 0; k < 3; k++) begin
                r_om[k] <= rnd_mag(66'(r_op[k][0]) + 66'(r_op[k][1]) + 66'(r_op[k][2]));
                r_on[k] <= (66'(r_op[k][0]) + 66'(r_op[k][1]) + 66'(r_op[k][2])) < 0;
            end
            r_off <= n_off;
        end
    end

    // row serialiser: holds one finished item, hands out three transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sval <= 1'b0;
            r_row  <= lvm_pkg::ROW_SIDE;
        end else if (ser_load) begin
            r_sval <= 1'b1;
            r_row  <= lvm_pkg::ROW_SIDE;
        end else if (r_sval && i_out_ready) begin
            if (r_row == lvm_pkg::ROW_FWD) r_sval <= 1'b0;
            else                           r_row  <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            for (int j = 0; j < 3; j++) begin
                r_ax[0][j] <= r_s[S_OFF][j];
                r_ax[1][j] <= r_u[S_OFF][j];
                r_ax[2][j] <= r_f[S_OFF][j];
            end
            r_of <= r_off;
            r_dg <= r_ctx[S_OFF].degen;
        end
    end

    always_comb begin
        o_out_valid           = r_sval;
        o_out_data.row        = r_row;
        o_out_data.axis_x     = '0;
        o_out_data.axis_y     = '0;
        o_out_data.axis_z     = '0;
        o_out_data.offset     = '0;
        case (r_row)
            lvm_pkg::ROW_SIDE, lvm_pkg::ROW_UP, lvm_pkg::ROW_FWD: begin
                o_out_data.axis_x = r_ax[r_row][0];
                o_out_data.axis_y = r_ax[r_row][1];
                o_out_data.axis_z = r_ax[r_row][2];
                o_out_data.offset = r_of[r_row];
            end
            default: ;
        endcase
        o_out_data.degenerate = r_dg;
        o_out_data.last       = (r_row == lvm_pkg::ROW_FWD);
    end

endmodule

>>> tb/lookat_view_matrix_core_tb.sv
`timescale 1ns / 1ps
// Testbench for lookat_view_matrix_core: directed and random camera poses,
// three rows predicted per transaction and checked in order. Depends on lvm_pkg.
module lookat_view_matrix_core_tb;

    class row_scoreboard;
        lvm_pkg::t_out pending[$];
        int            errors;

        function logic [63:0] isqrt(logic [63:0] v);
            logic [63:0] r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function longint round30(longint v);
            logic [63:0] m;
            m = (v < 0) ? -v : v;
            m = (m + (64'd1 << 29)) >> 30;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function longint clamp_unit(longint v);
            if (v > 64'sd1073741824) return 64'sd1073741824;
            if (v < -64'sd1073741824) return -64'sd1073741824;
            return v;
        endfunction

        // unit vector in Q2.30 of a nonzero vector
        function void normalise(input longint d[3], output longint o[3]);
            logic [63:0] mag[3];
            logic [63:0] m, sum, len, q;
            m = 0;
            sum = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = (d[i] < 0) ? -d[i] : d[i];
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0) begin
                o = '{0, 0, 0};
                return;
            end
            while (m >= (64'd1 << 30)) begin
                for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
                m = m >> 1;
            end
            while (m < (64'd1 << 29)) begin
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
                m = m << 1;
            end
            for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
            len = isqrt(sum);
            for (int i = 0; i < 3; i++) begin
                q = ((mag[i] << 30) + len / 2) / len;
                o[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
            end
        endfunction

        function void note_input(lvm_pkg::t_in t);
            longint eye[3], d[3], f[3], sv[3], s[3], u[3], ax[3], sum, off;
            logic flat;
            lvm_pkg::t_out r;
            eye = '{longint'(t.eye_x), longint'(t.eye_y), longint'(t.eye_z)};
            d[0] = longint'(t.target_x) - eye[0];
            d[1] = longint'(t.target_y) - eye[1];
            d[2] = longint'(t.target_z) - eye[2];
            flat = (d[0] == 0) && (d[2] == 0);
            f = '{0, 0, 0};
            s = '{0, 0, 0};
            u = '{0, 0, 0};
            if (!flat) begin
                normalise(d, f);
                sv = '{d[2], 0, -d[0]};
                normalise(sv, s);
                u[0] = clamp_unit(round30(f[1] * s[2]));
                u[1] = clamp_unit(round30(f[2] * s[0] - f[0] * s[2]));
                u[2] = clamp_unit(round30(-(f[1] * s[0])));
            end
            for (int k = 0; k < 3; k++) begin
                case (k)
                    0: ax = s;
                    1: ax = u;
                    default: ax = f;
                endcase
                off = 0;
                if (!flat) begin
                    sum = ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2];
                    off = -round30(sum);
                    if (off > 64'sd2147483647) off = 64'sd2147483647;
                    if (off < -64'sd2147483648) off = -64'sd2147483648;
                end
                r.row        = (k == 0) ? lvm_pkg::ROW_SIDE :
                               (k == 1) ? lvm_pkg::ROW_UP : lvm_pkg::ROW_FWD;
                r.axis_x     = ax[0][31:0];
                r.axis_y     = ax[1][31:0];
                r.axis_z     = ax[2][31:0];
                r.offset     = off[31:0];
                r.degenerate = flat;
                r.last       = (k == 2);
                pending.push_back(r);
            end
        endfunction

        function void check_row(lvm_pkg::t_out got);
            lvm_pkg::t_out e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected row, actual %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                $display("%0t: row mismatch, expected %p, actual %p", $time, e, got);
                errors++;
            end
        endfunction
    endclass

    logic           i_clk, i_rst_n, i_in_valid, i_out_ready;
    logic           o_in_ready, o_out_valid;
    lvm_pkg::t_in   i_in_data;
    lvm_pkg::t_out  o_out_data;
    int             src_idle, snk_idle;
    row_scoreboard  sb;

    lookat_view_matrix_core dut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("tb: failure");
        $finish;
    end

    // receiver with random stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_row(o_out_data);
        i_out_ready <= ($urandom_range(99) >= snk_idle);
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return 32'h8000_0000 + $urandom_range(3);
            3: return $urandom_range(7) - 3;
            default: return {{8{$urandom_range(1) == 1}}, 24'($urandom)};
        endcase
    endfunction

    task automatic send(lvm_pkg::t_in t);
        while ($urandom_range(99) < src_idle) begin
            i_in_valid <= 0;
            @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data  <= t;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(t);
    endtask

    task automatic send_random();
        lvm_pkg::t_in t;
        t = {rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), rand_coord()};
        case ($urandom_range(9))
            0: t.target_x = t.eye_x;
            1: begin
                t.target_x = t.eye_x;
                t.target_z = t.eye_z;
            end
            2: t.target_z = t.eye_z;
            default: ;
        endcase
        send(t);
    endtask

    localparam logic [31:0] MAXP = 32'h7fff_ffff;
    localparam logic [31:0] MAXN = 32'h8000_0000;

    initial begin
        sb = new();
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_data = '0;
        src_idle = 38;
        snk_idle = 54;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: zero direction, parallel to up, axis-aligned, extremes
        send('{0, 0, 0, 0, 0, 0});
        send('{32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h20000, 32'h30000});
        send('{0, 0, 0, 0, 32'h50000, 0});
        send('{0, MAXP, 0, 0, MAXN, 0});
        send('{0, 0, 0, 0, 0, 32'h10000});
        send('{0, 0, 0, 0, 0, 32'hffff_0000});
        send('{0, 0, 0, 32'h10000, 0, 0});
        send('{0, 0, 0, 32'hffff_0000, 0, 0});
        send('{0, 0, 0, 32'h10000, 32'h10000, 32'h10000});
        send('{MAXN, MAXN, MAXN, MAXP, MAXP, MAXP});
        send('{MAXP, MAXP, MAXP, MAXN, MAXN, MAXN});
        send('{MAXP, MAXN, MAXP, MAXN, MAXP, MAXN});
        send('{MAXN, MAXP, MAXN, MAXN, MAXN, MAXN + 1});
        send('{MAXP, 0, MAXN, MAXP - 1, 0, MAXN});
        send('{0, 0, 0, 1, MAXP, 0});
        send('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0});
        for (int i = 0; i < 120; i++) begin
            if (i == 40) begin
                src_idle = 54;
                snk_idle = 38;
            end else if (i == 80) begin
                src_idle = 0;
                snk_idle = 0;
            end
            send_random();
        end
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> filelist.f
design/lvm_pkg.sv
design/lookat_view_matrix_core.sv
tb/lookat_view_matrix_core_tb.sv
